[sv/stp_pkg.sv]
package stp_pkg;

    localparam logic [31:0] STP_MAX_STRING_LENGTH = 32'd65535;
    localparam logic [31:0] STP_COUNT_LIMIT       = 32'd65535;

    localparam int unsigned STP_BASE_W  = 6;
    localparam int unsigned STP_VALUE_W = 64;
    localparam int unsigned STP_COUNT_W = 16;

    localparam logic [STP_BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [STP_BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [STP_BASE_W-1:0] BASE_TWO  = 6'd2;
    localparam logic [STP_BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [STP_BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [STP_BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [STP_BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [STP_BASE_W-1:0]  BASE_RESET = BASE_DEC;
    localparam logic [STP_VALUE_W-1:0] LOW_RESET  = '0;
    localparam logic [STP_VALUE_W-1:0] HIGH_RESET = '1;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_DIGIT0   = 8'h30;
    localparam logic [7:0] CH_DIGIT9   = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] LETTER_BIAS = 8'd10;
    localparam logic [7:0] NO_DIGIT    = 8'hff;

    typedef enum logic [1:0] {
        CFG_NUMBER_BASE = 2'd0,
        CFG_LOW_LIMIT   = 2'd1,
        CFG_HIGH_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_BASE = 3'd1,
        ST_NONE     = 3'd2,
        ST_TRAILING = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        PH_WS   = 6'b000001,
        PH_PFX  = 6'b000010,
        PH_ZERO = 6'b000100,
        PH_DIG  = 6'b001000,
        PH_STOP = 6'b010000,
        PH_BAD  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [STP_BASE_W-1:0]  number_base;
        logic [STP_VALUE_W-1:0] low_limit;
        logic [STP_VALUE_W-1:0] high_limit;
    } t_cfg;

    typedef struct packed {
        logic [STP_VALUE_W-1:0] value;
        logic [2:0]             status;
        logic                   error_flag;
        logic [STP_COUNT_W-1:0] end_offset;
    } t_result;

endpackage

[sv/stp_char_if.sv]
interface stp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

[sv/stp_result_if.sv]
interface stp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  status;
    logic        error_flag;
    logic [15:0] end_offset;

    modport source (output valid, output value, output status, output error_flag,
                    output end_offset, input ready);
    modport sink (input valid, input value, input status, input error_flag,
                  input end_offset, output ready);
endinterface

[sv/stp_cfg_regs.sv]
module stp_cfg_regs
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_BASE: n_cfg.number_base = i_cfg_data[STP_BASE_W-1:0];
                CFG_LOW_LIMIT:   n_cfg.low_limit   = i_cfg_data;
                CFG_HIGH_LIMIT:  n_cfg.high_limit  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base <= BASE_RESET;
            r_cfg.low_limit   <= LOW_RESET;
            r_cfg.high_limit  <= HIGH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/stp_in_stage.sv]
module stp_in_stage
    import stp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_byte,
    input  logic       i_out_free,
    output logic       o_ready,
    output logic       o_adv,
    output logic [7:0] o_char_byte
);

    logic       r_vld;
    logic [7:0] r_byte;

    // a terminator needs room in the result register, other characters do not
    assign o_adv   = r_vld && ((r_byte != CH_NUL) || i_out_free);
    assign o_ready = !r_vld || o_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_char_byte;
        end
    end

    assign o_char_byte = r_byte;

endmodule

[sv/stp_step.sv]
module stp_step
    import stp_pkg::*;
#(
    parameter logic [31:0] MAX_STRING_LENGTH = STP_MAX_STRING_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_char_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    localparam logic [STP_COUNT_W-1:0] COUNT_CAP =
        (MAX_STRING_LENGTH > STP_COUNT_LIMIT) ? STP_COUNT_LIMIT[STP_COUNT_W-1:0]
                                              : MAX_STRING_LENGTH[STP_COUNT_W-1:0];

    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [STP_BASE_W-1:0]  r_base, n_base;
    logic [STP_VALUE_W-1:0] r_acc, n_acc;
    logic                   r_ovf, n_ovf;
    logic [STP_COUNT_W-1:0] r_cnt, n_cnt;

    logic                   first_char;
    logic                   bad_base;
    t_phase                 phase_cur;
    logic [STP_BASE_W-1:0]  base_cur;
    logic [STP_BASE_W-1:0]  pfx_base;
    logic [STP_BASE_W-1:0]  pfx_digit_base;
    logic [STP_BASE_W-1:0]  digit_base;
    logic [7:0]             lower_ch;
    logic [7:0]             digit;
    logic [69:0]            mul;
    logic [70:0]            prod;
    logic                   digit_ok;
    logic                   digit_fits;
    logic                   is_space;
    logic                   is_sign;
    logic                   is_zero_ch;
    logic                   do_prefix;
    logic                   do_digit;
    logic [STP_COUNT_W-1:0] cnt_inc;
    logic [STP_VALUE_W-1:0] signed_val;

    always_comb begin
        first_char = (r_phase == PH_WS) && (r_cnt == '0);
        bad_base   = (i_cfg.number_base == BASE_ONE) || (i_cfg.number_base > BASE_MAX);
        base_cur   = first_char ? i_cfg.number_base : r_base;
        phase_cur  = (first_char && bad_base) ? PH_BAD : r_phase;

        lower_ch   = i_char_byte | CASE_BIT;
        is_space   = (i_char_byte == CH_SPACE) ||
                     ((i_char_byte >= CH_TAB) && (i_char_byte <= CH_CR));
        is_sign    = (i_char_byte == CH_MINUS) || (i_char_byte == CH_PLUS);
        is_zero_ch = (i_char_byte == CH_DIGIT0);

        if (lower_ch >= CH_LOWER_A) begin
            digit = lower_ch - CH_LOWER_A + LETTER_BIAS;
        end else if ((i_char_byte >= CH_DIGIT0) && (i_char_byte <= CH_DIGIT9)) begin
            digit = i_char_byte - CH_DIGIT0;
        end else begin
            digit = NO_DIGIT;
        end

        // hex with a leading zero falls back to automatic detection
        pfx_base       = ((base_cur == BASE_HEX) && is_zero_ch) ? BASE_AUTO : base_cur;
        pfx_digit_base = (pfx_base == BASE_AUTO) ? BASE_DEC : pfx_base;

        unique case (phase_cur)
            PH_ZERO: digit_base = BASE_OCT;
            PH_DIG:  digit_base = base_cur;
            default: digit_base = pfx_digit_base;
        endcase

        mul        = 70'(r_acc) * 70'(digit_base);
        prod       = 71'(mul) + 71'(digit);
        digit_ok   = (digit_base >= BASE_TWO) && (digit < 8'(digit_base));
        digit_fits = prod <= 71'(i_cfg.high_limit);

        cnt_inc = (r_cnt < COUNT_CAP) ? r_cnt + 1'b1 : r_cnt;
    end

    always_comb begin
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_base    = r_base;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_cnt     = r_cnt;
        do_prefix = 1'b0;
        do_digit  = 1'b0;

        if (i_char_byte != CH_NUL) begin
            n_phase = phase_cur;
            n_base  = base_cur;
            unique case (phase_cur)
                PH_WS: begin
                    if (is_space) begin
                        n_cnt = cnt_inc;
                    end else if (is_sign) begin
                        n_neg   = (i_char_byte == CH_MINUS);
                        n_cnt   = cnt_inc;
                        n_phase = PH_PFX;
                    end else begin
                        do_prefix = 1'b1;
                    end
                end
                PH_PFX: begin
                    do_prefix = 1'b1;
                end
                PH_ZERO: begin
                    if (lower_ch == CH_LOWER_X) begin
                        n_base  = BASE_HEX;
                        n_cnt   = cnt_inc;
                        n_phase = PH_DIG;
                    end else begin
                        n_base   = BASE_OCT;
                        do_digit = 1'b1;
                    end
                end
                PH_DIG: begin
                    do_digit = 1'b1;
                end
                default: ;
            endcase

            if (do_prefix) begin
                if ((pfx_base == BASE_AUTO) && is_zero_ch) begin
                    n_base  = BASE_AUTO;
                    n_cnt   = cnt_inc;
                    n_phase = PH_ZERO;
                end else begin
                    n_base   = pfx_digit_base;
                    do_digit = 1'b1;
                end
            end

            if (do_digit) begin
                if (!digit_ok) begin
                    n_phase = PH_STOP;
                end else if (!digit_fits) begin
                    n_ovf   = 1'b1;
                    n_phase = PH_STOP;
                end else begin
                    n_acc   = prod[STP_VALUE_W-1:0];
                    n_cnt   = cnt_inc;
                    n_phase = PH_DIG;
                end
            end
        end else begin
            n_phase = PH_WS;
            n_neg   = 1'b0;
            n_base  = BASE_AUTO;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_cnt   = '0;
        end
    end

    always_comb begin
        signed_val = r_neg ? (STP_VALUE_W'(0) - r_acc) : r_acc;
        o_res.value      = signed_val;
        o_res.status     = ST_OK;
        o_res.end_offset = r_cnt;
        if (phase_cur == PH_BAD) begin
            o_res.value      = '0;
            o_res.status     = ST_BAD_BASE;
            o_res.end_offset = '0;
        end else begin
            if (phase_cur == PH_STOP) begin
                o_res.status = (r_cnt == '0) ? ST_NONE : ST_TRAILING;
            end
            if (r_ovf) begin
                o_res.value  = i_cfg.high_limit;
                o_res.status = ST_RANGE;
            end else if (!r_neg && (i_cfg.low_limit > signed_val)) begin
                o_res.value  = i_cfg.low_limit;
                o_res.status = ST_RANGE;
            end
        end
        o_res.error_flag = (o_res.status != ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WS;
            r_neg   <= 1'b0;
            r_base  <= BASE_AUTO;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_char_byte == CH_NUL)) |=>
            ((r_phase == PH_WS) && (r_cnt == '0) && !r_ovf && !r_neg))
        else $error("state not cleared after terminator");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= COUNT_CAP)
        else $error("consumed count above cap");

    a_ovf_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_phase == PH_STOP))
        else $error("overflow without stop");

endmodule

[sv/stp_out_stage.sv]
module stp_out_stage
    import stp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

[sv/string_to_unsigned_parser.sv]
// Parses a zero-terminated text number arriving one character per item and returns one
// result item (value, status, error flag, end offset) for each terminating zero byte; no
// other character produces a result. A character item is taken every clock cycle unless a
// terminator waits for the result register; each item is held in the input register and
// then folded into the parser state, where one 64x6 multiply-add and a 71-bit compare
// against the high limit set the cycle time. The result is loaded into the output register
// as the terminator leaves the input register, and further characters keep flowing while it
// waits to be taken; only a second terminator stalls until the result register is free.
// The radix is sampled with the first character of each string, the limits are read live.
// The user must write configuration only while no string is in progress; not enforced here.
module string_to_unsigned_parser
    import stp_pkg::*;
#(
    parameter logic [31:0] MAX_STRING_LENGTH = STP_MAX_STRING_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    stp_char_if.sink            i_char,
    stp_result_if.source        o_result
);

    t_cfg       cfg;
    logic       out_free;
    logic       adv;
    logic [7:0] char_byte;
    t_result    step_res;
    t_result    out_res;
    logic       out_valid;

    stp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    stp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_char.valid),
        .i_char_byte (i_char.char_byte),
        .i_out_free  (out_free),
        .o_ready     (i_char.ready),
        .o_adv       (adv),
        .o_char_byte (char_byte)
    );

    stp_step #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_char_byte (char_byte),
        .i_cfg       (cfg),
        .o_res       (step_res)
    );

    stp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && (char_byte == CH_NUL)),
        .i_res   (step_res),
        .i_ready (o_result.ready),
        .o_valid (out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_result.valid      = out_valid;
    assign o_result.value      = out_res.value;
    assign o_result.status     = out_res.status;
    assign o_result.error_flag = out_res.error_flag;
    assign o_result.end_offset = out_res.end_offset;

endmodule

[dv/tb_string_to_unsigned_parser.sv]
module tb_string_to_unsigned_parser;
    import stp_pkg::*;

    localparam int unsigned HOLD_CYCLES        = 300;
    localparam int unsigned QUIET_LIMIT        = 4000;
    localparam int unsigned SETTLE_CYCLES      = 8;
    localparam int unsigned RANDOM_CHAR_TARGET = 400;
    localparam int unsigned LONG_ZERO_RUN      = 40;
    localparam int unsigned MAX_REPORTS        = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_NUMBER_BASE;
    logic [63:0] cfg_data = '0;
    logic        tx_valid = 1'b0;
    logic [7:0]  tx_char = CH_NUL;
    logic        rx_ready = 1'b0;
    logic        char_taken = 1'b0;

    stp_char_if   char_if();
    stp_result_if result_if();

    assign char_if.valid     = tx_valid;
    assign char_if.char_byte = tx_char;
    assign result_if.ready   = rx_ready;

    string_to_unsigned_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_char     (char_if),
        .o_result   (result_if)
    );

    logic [7:0] pending_chars[$];
    t_result    expected_results[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned phase_count = 0;
    int unsigned random_char_total = 0;

    // parser copy
    logic [5:0]  reg_base;
    logic [63:0] reg_low;
    logic [63:0] reg_high;
    t_phase      prs_phase;
    logic        prs_negative;
    logic [5:0]  prs_base;
    logic [63:0] prs_accum;
    logic        prs_overflow;
    logic [15:0] prs_count;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] digit_value(input logic [7:0] ch);
        logic [7:0] folded;
        folded = ch | CASE_BIT;
        if (folded >= CH_LOWER_A)
            return folded - CH_LOWER_A + LETTER_BIAS;
        if (ch >= CH_DIGIT0 && ch <= CH_DIGIT9)
            return ch - CH_DIGIT0;
        return NO_DIGIT;
    endfunction

    task automatic clear_parse_state();
        prs_phase    = PH_WS;
        prs_negative = 1'b0;
        prs_base     = BASE_AUTO;
        prs_accum    = '0;
        prs_overflow = 1'b0;
        prs_count    = '0;
    endtask

    task automatic bump_count();
        if (32'(prs_count) < STP_COUNT_LIMIT)
            prs_count = prs_count + 16'd1;
    endtask

    task automatic accept_digit(input logic [7:0] ch);
        logic [7:0]  d;
        logic [63:0] quot;
        logic [63:0] rem;
        d = digit_value(ch);
        prs_phase = PH_DIG;
        if (prs_base < BASE_TWO || d >= 8'(prs_base)) begin
            prs_phase = PH_STOP;
        end else begin
            quot = reg_high / 64'(prs_base);
            rem  = reg_high % 64'(prs_base);
            if (prs_accum > quot || (prs_accum == quot && 64'(d) > rem)) begin
                prs_overflow = 1'b1;
                prs_phase    = PH_STOP;
            end else begin
                prs_accum = prs_accum * 64'(prs_base) + 64'(d);
                bump_count();
            end
        end
    endtask

    task automatic accept_lead(input logic [7:0] ch);
        if (prs_base == BASE_HEX && ch == CH_DIGIT0)
            prs_base = BASE_AUTO;
        if (prs_base == BASE_AUTO && ch == CH_DIGIT0) begin
            bump_count();
            prs_phase = PH_ZERO;
        end else begin
            if (prs_base == BASE_AUTO)
                prs_base = BASE_DEC;
            accept_digit(ch);
        end
    endtask

    task automatic parse_char(input logic [7:0] ch, output logic done, output t_result res);
        t_status     st;
        logic [63:0] v;
        done = 1'b0;
        res  = '0;
        if (prs_phase == PH_WS && prs_count == '0) begin
            prs_base = reg_base;
            if (prs_base == BASE_ONE || prs_base > BASE_MAX)
                prs_phase = PH_BAD;
        end
        if (ch != CH_NUL) begin
            case (prs_phase)
                PH_WS: begin
                    if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                        bump_count();
                    end else if (ch == CH_MINUS || ch == CH_PLUS) begin
                        prs_negative = (ch == CH_MINUS);
                        bump_count();
                        prs_phase = PH_PFX;
                    end else begin
                        accept_lead(ch);
                    end
                end
                PH_PFX: accept_lead(ch);
                PH_ZERO: begin
                    if ((ch | CASE_BIT) == CH_LOWER_X) begin
                        prs_base = BASE_HEX;
                        bump_count();
                        prs_phase = PH_DIG;
                    end else begin
                        prs_base = BASE_OCT;
                        accept_digit(ch);
                    end
                end
                PH_DIG: accept_digit(ch);
                default: ;
            endcase
        end else begin
            done = 1'b1;
            if (prs_phase == PH_BAD) begin
                res.value      = '0;
                res.status     = ST_BAD_BASE;
                res.error_flag = 1'b1;
                res.end_offset = '0;
            end else begin
                st = ST_OK;
                v  = prs_accum;
                if (prs_phase == PH_STOP)
                    st = (prs_count == '0) ? ST_NONE : ST_TRAILING;
                if (prs_negative)
                    v = -v;
                if (prs_overflow) begin
                    v  = reg_high;
                    st = ST_RANGE;
                end else if (!prs_negative && reg_low > v) begin
                    v  = reg_low;
                    st = ST_RANGE;
                end
                res.value      = v;
                res.status     = st;
                res.error_flag = (st != ST_OK);
                res.end_offset = prs_count;
            end
            clear_parse_state();
        end
    endtask

    // driver: hold an offered item until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else if (!tx_valid || char_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                tx_valid <= 1'b1;
                tx_char  <= pending_chars[0];
            end else begin
                tx_valid <= 1'b0;
                tx_char  <= 8'($urandom_range(255));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            rx_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result made;
        logic    done;
        logic    char_fire;
        logic    result_fire;
        char_fire   = i_rst_n && char_if.valid && char_if.ready;
        result_fire = i_rst_n && result_if.valid && result_if.ready;
        char_taken <= char_fire;
        if (result_fire) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: value=%h status=%0d err=%0b offset=%0d",
                             result_if.value, result_if.status, result_if.error_flag,
                             result_if.end_offset);
            end else begin
                want = expected_results.pop_front();
                if (result_if.value !== want.value || result_if.status !== want.status ||
                    result_if.error_flag !== want.error_flag ||
                    result_if.end_offset !== want.end_offset) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: want value=%h status=%0d err=%0b offset=%0d",
                                 want.value, want.status, want.error_flag, want.end_offset);
                        $display("          got  value=%h status=%0d err=%0b offset=%0d",
                                 result_if.value, result_if.status, result_if.error_flag,
                                 result_if.end_offset);
                    end
                end
            end
        end
        if (char_fire) begin
            void'(pending_chars.pop_front());
            parse_char(char_if.char_byte, done, made);
            if (done)
                expected_results.push_back(made);
        end
        if (char_fire || result_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUMBER_BASE: reg_base = data[5:0];
            CFG_LOW_LIMIT:   reg_low = data;
            CFG_HIGH_LIMIT:  reg_high = data;
            default: ;
        endcase
    endtask

    task automatic wait_results_done();
        while (pending_chars.size() != 0 || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(input logic [5:0] base, input logic [63:0] low,
                               input logic [63:0] high);
        wait_results_done();
        write_reg(CFG_NUMBER_BASE, 64'(base));
        write_reg(CFG_LOW_LIMIT, low);
        write_reg(CFG_HIGH_LIMIT, high);
        case (phase_count % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
            default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
        endcase
        phase_count++;
        @(posedge i_clk);
    endtask

    task automatic queue_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            pending_chars.push_back(8'(text[i]));
        pending_chars.push_back(CH_NUL);
    endtask

    task automatic queue_random_string(input logic [5:0] base);
        int unsigned n;
        int unsigned r;
        int unsigned d;
        int unsigned dbase;
        int unsigned start;
        start = pending_chars.size();
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(6);
            repeat (n) pending_chars.push_back(8'($urandom_range(255, 1)));
        end else begin
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(3, 1);
                repeat (n) begin
                    r = $urandom_range(5);
                    pending_chars.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
                end
            end
            r = $urandom_range(3);
            if (r == 0)
                pending_chars.push_back(CH_PLUS);
            else if (r == 1)
                pending_chars.push_back(CH_MINUS);
            dbase = base;
            if (base == BASE_AUTO || base == BASE_HEX) begin
                r = $urandom_range(3);
                if (r == 0) begin
                    pending_chars.push_back(CH_DIGIT0);
                    pending_chars.push_back($urandom_range(1) ? CH_LOWER_X
                                                              : CH_LOWER_X ^ CASE_BIT);
                    dbase = BASE_HEX;
                end else if (r == 1) begin
                    pending_chars.push_back(CH_DIGIT0);
                    dbase = BASE_OCT;
                end else begin
                    dbase = (base == BASE_AUTO) ? BASE_DEC : BASE_HEX;
                end
            end
            if (dbase < BASE_TWO || dbase > BASE_MAX)
                dbase = BASE_DEC;
            n = ($urandom_range(4) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
            repeat (n) begin
                d = $urandom_range(dbase - 1);
                if (d < 10)
                    pending_chars.push_back(CH_DIGIT0 + 8'(d));
                else if ($urandom_range(1))
                    pending_chars.push_back(CH_LOWER_A + 8'(d - 10));
                else
                    pending_chars.push_back((CH_LOWER_A ^ CASE_BIT) + 8'(d - 10));
            end
            if ($urandom_range(4) == 0) begin
                n = $urandom_range(3, 1);
                repeat (n) pending_chars.push_back(8'($urandom_range(255, 1)));
            end
        end
        pending_chars.push_back(CH_NUL);
        random_char_total += pending_chars.size() - start;
    endtask

    function automatic logic [63:0] pick_low();
        case ($urandom_range(3))
            2: return 64'($urandom_range(1000));
            3: return {$urandom, $urandom};
            default: return '0;
        endcase
    endfunction

    function automatic logic [63:0] pick_high();
        case ($urandom_range(3))
            2: return 64'($urandom_range(100000));
            3: return {$urandom, $urandom};
            default: return '1;
        endcase
    endfunction

    initial begin : stimulus
        int unsigned r;
        logic [5:0]  base;
        reg_base = BASE_RESET;
        reg_low  = LOW_RESET;
        reg_high = HIGH_RESET;
        clear_parse_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        start_phase(BASE_DEC, LOW_RESET, HIGH_RESET);
        queue_text("");
        queue_text("18446744073709551615");
        queue_text("18446744073709551616");
        queue_text(" \011\012\013\014\015-1");
        queue_text("+42abc");
        queue_text("xyz");
        queue_text("-");
        queue_text("0");

        start_phase(BASE_AUTO, LOW_RESET, HIGH_RESET);
        queue_text("0x1F");
        queue_text("0XfF");
        queue_text("0x");
        queue_text("0xg");
        queue_text("017");
        queue_text("09");
        queue_text("-0x10");
        repeat (8) queue_random_string(BASE_AUTO);

        // stall the result side long enough to back up the input
        start_phase(BASE_HEX, 64'd100, 64'd5000);
        queue_text("0x20");
        queue_text("FFFF");
        repeat (12) queue_random_string(BASE_HEX);
        hold_req++;

        start_phase(BASE_MAX, '1, HIGH_RESET);
        repeat (8) queue_random_string(BASE_MAX);

        start_phase(BASE_TWO, LOW_RESET, '0);
        queue_text("0001");
        repeat (8) queue_random_string(BASE_TWO);

        start_phase(BASE_ONE, LOW_RESET, HIGH_RESET);
        repeat (3) queue_random_string(BASE_ONE);
        start_phase(BASE_MAX + 6'd1, LOW_RESET, HIGH_RESET);
        repeat (3) queue_random_string(BASE_MAX + 6'd1);
        start_phase('1, LOW_RESET, HIGH_RESET);
        repeat (3) queue_random_string('1);

        start_phase(BASE_DEC, LOW_RESET, HIGH_RESET);
        repeat (LONG_ZERO_RUN) pending_chars.push_back(CH_DIGIT0);
        pending_chars.push_back(CH_DIGIT0 + 8'd7);
        pending_chars.push_back(CH_NUL);

        while (random_char_total < RANDOM_CHAR_TARGET) begin
            r = $urandom_range(9);
            if (r < 2)
                base = BASE_AUTO;
            else if (r == 2)
                base = BASE_HEX;
            else if (r == 3)
                base = $urandom_range(1) ? BASE_ONE : 6'($urandom_range(63, 37));
            else
                base = 6'($urandom_range(36, 2));
            start_phase(base, pick_low(), pick_high());
            repeat (8) queue_random_string(base);
        end

        wait_results_done();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
